/* src/bdtf_pkg.sv */
// ----------------------------------------------------------------------------
// bdtf_pkg
// shared types and constants of the barycentric depth-tested fragment unit
// ----------------------------------------------------------------------------
package bdtf_pkg;

    localparam int COORD_W  = 12;
    localparam int DEPTH_W  = 16;
    localparam int COLOR_W  = 24;
    // edge differences are 13 bits, products 26 bits, sums of two 27 bits
    localparam int DIFF_W   = 13;
    localparam int CROSS_W  = 28;
    // weighted depth sum: 16 x 28 products, three of them
    localparam int NUM_W    = 46;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FRAG = 1'b1;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [DEPTH_W-1:0] z;
    } vertex_t;

endpackage

/* src/bdtf_divider.sv */
// ----------------------------------------------------------------------------
// bdtf_divider
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module bdtf_divider
    import bdtf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [NUM_W-1:0]   dividend,
    input  logic        [CROSS_W-1:0] divisor,
    output logic                      done,
    output logic signed [DEPTH_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [CROSS_W:0]   rem_reg, rem_next;
    logic [CROSS_W-1:0] den_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [CROSS_W:0]   trial;
    logic [NUM_W-1:0]   mag;
    logic [NUM_W-1:0]   final_q;

    assign mag = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
    assign trial = {rem_reg[CROSS_W-1:0], quo_reg[NUM_W-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = mag;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
            neg_reg <= dividend[NUM_W-1];
        end
    end

    assign done     = busy_reg && !busy_next;
    // value after the final step is taken from quo_next
    assign final_q  = neg_reg ? (~quo_next + 1'b1) : quo_next;
    assign quotient = DEPTH_W'(final_q);

endmodule

/* src/bdtf_depth_mem.sv */
// ----------------------------------------------------------------------------
// bdtf_depth_mem
// depth store with registered read and a clearing pass after reset
// ----------------------------------------------------------------------------
module bdtf_depth_mem
    import bdtf_pkg::*;
#(
    parameter int DEPTH = 16384
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic signed [DEPTH_W-1:0]        rd_data,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic signed [DEPTH_W-1:0]        wr_data,
    output logic                             clearing
);

    localparam int AW = $clog2(DEPTH);

    logic signed [DEPTH_W-1:0] mem [DEPTH];
    logic [AW:0]               clr_reg, clr_next;

    assign clearing = (clr_reg != (AW+1)'(DEPTH));
    assign clr_next = clearing ? clr_reg + 1'b1 : clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else
            clr_reg <= clr_next;
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
            mem[clr_reg[AW-1:0]] <= DEPTH_MIN;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/barycentric_depth_tested_fragment_unit.sv */
// ----------------------------------------------------------------------------
// barycentric_depth_tested_fragment_unit
// triangle edge test, perspective-free depth interpolation and z-buffer test
// ----------------------------------------------------------------------------
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, vertex_slot, coord_x,  | to block
//          | coord_y, depth_z, fill_color                      |
//  out     | out_valid, out_stall, pixel_x, pixel_y,           | from block
//          | pixel_depth, pixel_color                          |
//
// a vertex load or an off-buffer fragment leaves in_stall low; a fragment inside
// the buffer holds in_stall through DIFF, CROSS, SIGN and MUL when rejected by the
// edge test, else also DIV (serial divider, one quotient bit per cycle) and TEST
// one fragment at a time: the depth store read, compare and write-back
// complete before the next transfer, so no forwarding is needed
// after reset the depth store is swept to its minimum, all FB_WIDTH*FB_HEIGHT
// entries, during which in_stall stays high
// a held result sits in the output register while the next item is taken;
// only a fragment that finds the output still full waits
// ----------------------------------------------------------------------------
module barycentric_depth_tested_fragment_unit
    import bdtf_pkg::*;
#(
    parameter int FB_WIDTH  = 128,
    parameter int FB_HEIGHT = 128
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      opcode,
    input  logic [1:0]                vertex_slot,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [DEPTH_W-1:0] depth_z,
    input  logic [COLOR_W-1:0]        fill_color,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [$clog2(FB_WIDTH)-1:0]  pixel_x,
    output logic [$clog2(FB_HEIGHT)-1:0] pixel_y,
    output logic signed [DEPTH_W-1:0] pixel_depth,
    output logic [COLOR_W-1:0]        pixel_color
);

    localparam int XW    = $clog2(FB_WIDTH);
    localparam int YW    = $clog2(FB_HEIGHT);
    localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIFF  = 7'b0000010,
        ST_CROSS = 7'b0000100,
        ST_SIGN  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_TEST  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    vertex_t vtx_reg [3];

    // fragment context
    logic [XW-1:0]        px_reg;
    logic [YW-1:0]        py_reg;
    logic [COLOR_W-1:0]   col_reg;
    logic signed [COORD_W-1:0] pcx_reg, pcy_reg;
    logic signed [DIFF_W-1:0] pax_reg, pay_reg, abx_reg, aby_reg, acx_reg, acy_reg;
    logic signed [CROSS_W-1:0] ux_reg, uy_reg, uz_reg, w0_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic                      reject_reg;
    logic                      div_start_reg;

    logic out_valid_reg;
    logic [XW-1:0] ox_reg;
    logic [YW-1:0] oy_reg;
    logic signed [DEPTH_W-1:0] od_reg;
    logic [COLOR_W-1:0] oc_reg;

    logic        clearing;
    logic signed [DEPTH_W-1:0] mem_rd;
    logic        mem_we;
    logic [AW-1:0] addr;
    logic        in_xfer, out_xfer, in_range, pass;
    logic        div_done;
    logic signed [DEPTH_W-1:0] div_q;
    logic signed [CROSS_W-1:0] sux, suy, suz;

    assign in_stall = clearing || (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_range = (int'(coord_x) >= 0) && (int'(coord_x) < FB_WIDTH)
                   && (int'(coord_y) >= 0) && (int'(coord_y) < FB_HEIGHT);

    // pixel address, row major
    assign addr = AW'(int'(py_reg) * FB_WIDTH + int'(px_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_xfer && opcode == OP_FRAG && in_range) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_CROSS;
            ST_CROSS: state_next = ST_SIGN;
            ST_SIGN:  state_next = ST_MUL;
            ST_MUL:   state_next = reject_reg ? ST_IDLE : ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_TEST;
            ST_TEST:  if (!out_valid_reg || out_xfer) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // normalize the sign so uz is positive
    assign sux = uz_reg[CROSS_W-1] ? -ux_reg : ux_reg;
    assign suy = uz_reg[CROSS_W-1] ? -uy_reg : uy_reg;
    assign suz = uz_reg[CROSS_W-1] ? -uz_reg : uz_reg;

    assign pass   = (state_reg == ST_TEST) && (!out_valid_reg || out_xfer)
                 && (mem_rd < depth_reg);
    assign mem_we = pass;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                vtx_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // divider starts once num_reg holds the weighted sum
            div_start_reg <= (state_reg == ST_MUL) && !reject_reg;
            if (pass)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
            if (in_xfer && opcode == OP_LOAD && vertex_slot != 2'd3)
                vtx_reg[vertex_slot] <= '{x: coord_x, y: coord_y, z: depth_z};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg  <= XW'(coord_x);
            py_reg  <= YW'(coord_y);
            col_reg <= fill_color;
            pcx_reg <= coord_x;
            pcy_reg <= coord_y;
        end
        if (state_reg == ST_DIFF)
        begin
            pax_reg <= DIFF_W'(vtx_reg[0].x) - DIFF_W'(pcx_reg);
            pay_reg <= DIFF_W'(vtx_reg[0].y) - DIFF_W'(pcy_reg);
            abx_reg <= DIFF_W'(vtx_reg[1].x) - DIFF_W'(vtx_reg[0].x);
            aby_reg <= DIFF_W'(vtx_reg[1].y) - DIFF_W'(vtx_reg[0].y);
            acx_reg <= DIFF_W'(vtx_reg[2].x) - DIFF_W'(vtx_reg[0].x);
            acy_reg <= DIFF_W'(vtx_reg[2].y) - DIFF_W'(vtx_reg[0].y);
        end
        if (state_reg == ST_CROSS)
        begin
            ux_reg <= CROSS_W'(abx_reg * pay_reg) - CROSS_W'(pax_reg * aby_reg);
            uy_reg <= CROSS_W'(pax_reg * acy_reg) - CROSS_W'(acx_reg * pay_reg);
            uz_reg <= CROSS_W'(acx_reg * aby_reg) - CROSS_W'(abx_reg * acy_reg);
        end
        if (state_reg == ST_SIGN)
        begin
            ux_reg     <= sux;
            uy_reg     <= suy;
            uz_reg     <= suz;
            w0_reg     <= suz - sux - suy;
            reject_reg <= (uz_reg == '0) || sux[CROSS_W-1] || suy[CROSS_W-1]
                       || ((suz - sux - suy) < 0);
        end
        if (state_reg == ST_MUL)
            num_reg <= NUM_W'(vtx_reg[0].z * w0_reg) + NUM_W'(vtx_reg[1].z * uy_reg)
                     + NUM_W'(vtx_reg[2].z * ux_reg);
        if (div_done)
            depth_reg <= div_q;
        if (pass)
        begin
            ox_reg <= px_reg;
            oy_reg <= py_reg;
            od_reg <= depth_reg;
            oc_reg <= col_reg;
        end
    end

    bdtf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (num_reg),
        .divisor  (CROSS_W'(uz_reg)),
        .done     (div_done),
        .quotient (div_q)
    );

    // read issued while dividing, data ready by the compare
    bdtf_depth_mem #(.DEPTH(DEPTH)) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (addr),
        .rd_data  (mem_rd),
        .wr_en    (mem_we),
        .wr_addr  (addr),
        .wr_data  (depth_reg),
        .clearing (clearing)
    );

    assign out_valid   = out_valid_reg;
    assign pixel_x     = ox_reg;
    assign pixel_y     = oy_reg;
    assign pixel_depth = od_reg;
    assign pixel_color = oc_reg;

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken during fragment work");
    a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !mem_we)
        else $error("depth write during clearing pass");
    a_pass_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
        pass |=> out_valid_reg)
        else $error("passing fragment lost");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(pixel_depth))
        else $error("stalled result changed");

endmodule
